// ===== src/cbf_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and the multiplier table shared by the clause filter modules.
package cbf_pkg;

    localparam int HASH_COUNT = 4;
    localparam int KEY_W      = $clog2(HASH_COUNT);
    localparam int ELEM_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int ROW_BITS   = 64;
    localparam int ROW_SHIFT  = $clog2(ROW_BITS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [KEY_W-1:0]   KEY_LAST  = KEY_W'(HASH_COUNT - 1);

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic admitted;
        logic too_long;
    } t_result;

    typedef enum logic [1:0] {
        JOB_CLEAR = 2'd0,
        JOB_LONG  = 2'd1,
        JOB_UNIT  = 2'd2,
        JOB_TEST  = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind                           kind;
        logic [HASH_COUNT-1:0][ELEM_W-1:0]   sums;
    } t_job;

    function automatic logic [ELEM_W-1:0] prime(input logic [3:0] idx);
        logic [ELEM_W-1:0] p;
        case (idx)
            4'd0:    p = 32'd2038072819;
            4'd1:    p = 32'd2038073287;
            4'd2:    p = 32'd2038073761;
            4'd3:    p = 32'd2038074317;
            4'd4:    p = 32'd2038072823;
            4'd5:    p = 32'd2038073321;
            4'd6:    p = 32'd2038073767;
            4'd7:    p = 32'd2038074319;
            4'd8:    p = 32'd2038072847;
            4'd9:    p = 32'd2038073341;
            4'd10:   p = 32'd2038073789;
            4'd11:   p = 32'd2038074329;
            4'd12:   p = 32'd2038074751;
            4'd13:   p = 32'd2038075231;
            4'd14:   p = 32'd2038075751;
            default: p = 32'd2038076267;
        endcase
        return p;
    endfunction

endpackage

// ===== src/cbf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cbf_front.sv =====
`timescale 1ns / 1ps
// Front end: takes items, keeps the running hashes and length, queues clause jobs.
module cbf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  cbf_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [cbf_pkg::COUNT_W-1:0]  i_cfg_wdata,
    output logic                         o_push,
    output cbf_pkg::t_job                o_job
);

    logic [cbf_pkg::COUNT_W-1:0] r_max_len;
    logic [cbf_pkg::COUNT_W-1:0] r_count;
    logic [cbf_pkg::COUNT_W-1:0] n_count;
    logic [cbf_pkg::COUNT_W-1:0] lits;
    logic [cbf_pkg::HASH_COUNT-1:0][cbf_pkg::ELEM_W-1:0] r_sums;
    logic [cbf_pkg::HASH_COUNT-1:0][cbf_pkg::ELEM_W-1:0] n_sums;
    logic [cbf_pkg::HASH_COUNT-1:0][cbf_pkg::ELEM_W-1:0] prod;
    logic [cbf_pkg::ELEM_W-1:0]  elem_u;
    logic                        too_long;
    logic                        is_clear;

    assign elem_u   = i_item.element[cbf_pkg::ELEM_W-1:0];
    assign is_clear = (i_item.command == cbf_pkg::CMD_CLEAR);

    always_comb begin
        for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
            prod[k] = elem_u * cbf_pkg::prime(elem_u[3:0] ^ 4'(k + 1));
            // the glue word does not enter the hashes
            n_sums[k] = (r_count != '0) ? (r_sums[k] ^ prod[k]) : r_sums[k];
        end
    end

    assign n_count  = (r_count == cbf_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    // glue-only clause counts as one literal
    assign lits     = (n_count > 16'd1) ? n_count - 1'b1 : n_count;
    assign too_long = (r_max_len != '0) && (lits > r_max_len);

    assign o_push = i_accept && (is_clear || i_item.last);

    always_comb begin
        o_job.sums = n_sums;
        if (is_clear) begin
            o_job.kind = cbf_pkg::JOB_CLEAR;
        end else if (too_long) begin
            o_job.kind = cbf_pkg::JOB_LONG;
        end else if (lits == 16'd1) begin
            o_job.kind = cbf_pkg::JOB_UNIT;
        end else begin
            o_job.kind = cbf_pkg::JOB_TEST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= '0;
            r_count   <= '0;
            r_sums    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (i_accept && !is_clear) begin
                if (i_item.last) begin
                    r_count <= '0;
                    r_sums  <= '0;
                end else begin
                    r_count <= n_count;
                    r_sums  <= n_sums;
                end
            end
        end
    end

endmodule

// ===== src/cbf_job_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the bit-store engine.
module cbf_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbf_pkg::t_job  i_job,
    input  logic           i_pop,
    output cbf_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbf_pkg::t_job     r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/cbf_back.sv =====
`timescale 1ns / 1ps
// Back end: reduces hashes, tests and sets the bit store, sweeps it clear.
module cbf_back #(
    parameter int FILTER_BITS = 1048576
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  cbf_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_init,
    output logic              o_done,
    output cbf_pkg::t_result  o_result
);

    localparam int ROWS     = (FILTER_BITS + cbf_pkg::ROW_BITS - 1) / cbf_pkg::ROW_BITS;
    localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam bit IS_POW2  = ((FILTER_BITS & (FILTER_BITS - 1)) == 0);

    localparam logic [cbf_pkg::ELEM_W-1:0] MODULUS  = cbf_pkg::ELEM_W'(FILTER_BITS);
    localparam logic [cbf_pkg::ELEM_W-1:0] MOD_MASK = cbf_pkg::ELEM_W'(FILTER_BITS - 1);
    // floor(2^32 / FILTER_BITS); the quotient estimate is low by at most one
    localparam logic [cbf_pkg::ELEM_W-1:0] RECIP    =
        cbf_pkg::ELEM_W'(64'h1_0000_0000 / 64'(FILTER_BITS));
    localparam logic [RAW-1:0]             ROW_LAST = RAW'(ROWS - 1);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CLR  = 9'b000000010,
        ST_QMUL = 9'b000000100,
        ST_QSUB = 9'b000001000,
        ST_QFIX = 9'b000010000,
        ST_TRD  = 9'b000100000,
        ST_TCHK = 9'b001000000,
        ST_SRD  = 9'b010000000,
        ST_SWR  = 9'b100000000
    } t_state;

    t_state                                r_state;
    logic                                  r_init;
    logic [RAW-1:0]                        r_row;
    logic [cbf_pkg::KEY_W-1:0]             r_k;
    logic                                  r_all;
    logic [cbf_pkg::ELEM_W-1:0]            r_res [cbf_pkg::HASH_COUNT];
    logic [cbf_pkg::ELEM_W-1:0]            r_quo [cbf_pkg::HASH_COUNT];
    logic                                  r_done;
    cbf_pkg::t_result                      r_result;

    logic [2*cbf_pkg::ELEM_W-1:0]          quo_full [cbf_pkg::HASH_COUNT];
    logic [cbf_pkg::ELEM_W-1:0]            cur_res;
    logic [cbf_pkg::ELEM_W-1:0]            row_full;
    logic [RAW-1:0]                        cur_row;
    logic [cbf_pkg::ROW_SHIFT-1:0]         cur_bit;
    logic [cbf_pkg::ROW_BITS-1:0]          ram_rdata;
    logic [cbf_pkg::ROW_BITS-1:0]          ram_wdata;
    logic [RAW-1:0]                        ram_waddr;
    logic                                  ram_we;
    logic                                  all_now;

    always_comb begin
        for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
            quo_full[k] = {{cbf_pkg::ELEM_W{1'b0}}, r_res[k]}
                        * {{cbf_pkg::ELEM_W{1'b0}}, RECIP};
        end
    end

    assign cur_res  = r_res[r_k];
    assign row_full = cur_res >> cbf_pkg::ROW_SHIFT;
    assign cur_row  = row_full[RAW-1:0];
    assign cur_bit  = cur_res[cbf_pkg::ROW_SHIFT-1:0];
    assign all_now  = r_all && ram_rdata[cur_bit];

    assign ram_we    = (r_state == ST_CLR) || (r_state == ST_SWR);
    assign ram_waddr = (r_state == ST_CLR) ? r_row : cur_row;
    assign ram_wdata = (r_state == ST_CLR) ? '0
                     : (ram_rdata | (cbf_pkg::ROW_BITS'(1) << cur_bit));

    cbf_ram #(
        .WIDTH (cbf_pkg::ROW_BITS),
        .DEPTH (ROWS)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cur_row),
        .o_rdata (ram_rdata)
    );

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign o_init   = r_init;
    assign o_done   = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_init  <= 1'b1;
            r_row   <= '0;
            r_k     <= '0;
            r_all   <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_job.kind)
                            cbf_pkg::JOB_CLEAR: begin
                                r_row   <= '0;
                                r_state <= ST_CLR;
                            end
                            cbf_pkg::JOB_LONG: begin
                                r_done            <= 1'b1;
                                r_result.admitted <= 1'b0;
                                r_result.too_long <= 1'b1;
                            end
                            cbf_pkg::JOB_UNIT: begin
                                r_done            <= 1'b1;
                                r_result.admitted <= 1'b1;
                                r_result.too_long <= 1'b0;
                            end
                            cbf_pkg::JOB_TEST: begin
                                r_k   <= '0;
                                r_all <= 1'b1;
                                for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
                                    r_res[k] <= IS_POW2 ? (i_job.sums[k] & MOD_MASK)
                                                        : i_job.sums[k];
                                end
                                r_state <= IS_POW2 ? ST_TRD : ST_QMUL;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_CLR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == ROW_LAST) begin
                        r_init  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_QMUL: begin
                    // quotient estimate by reciprocal multiply, all four lanes
                    for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
                        r_quo[k] <= quo_full[k][2*cbf_pkg::ELEM_W-1:cbf_pkg::ELEM_W];
                    end
                    r_state <= ST_QSUB;
                end
                ST_QSUB: begin
                    for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
                        r_res[k] <= r_res[k] - r_quo[k] * MODULUS;
                    end
                    r_state <= ST_QFIX;
                end
                ST_QFIX: begin
                    // remainder is below twice the modulus here
                    for (int k = 0; k < cbf_pkg::HASH_COUNT; k++) begin
                        if (r_res[k] >= MODULUS) begin
                            r_res[k] <= r_res[k] - MODULUS;
                        end
                    end
                    r_state <= ST_TRD;
                end
                ST_TRD: begin
                    r_state <= ST_TCHK;
                end
                ST_TCHK: begin
                    r_all <= all_now;
                    if (r_k == cbf_pkg::KEY_LAST) begin
                        if (all_now) begin
                            r_done            <= 1'b1;
                            r_result.admitted <= 1'b0;
                            r_result.too_long <= 1'b0;
                            r_state           <= ST_IDLE;
                        end else begin
                            r_k     <= '0;
                            r_state <= ST_SRD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_TRD;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SWR;
                end
                ST_SWR: begin
                    if (r_k == cbf_pkg::KEY_LAST) begin
                        r_done            <= 1'b1;
                        r_result.admitted <= 1'b1;
                        r_result.too_long <= 1'b0;
                        r_state           <= ST_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_SRD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_done)
        else $error("result strobe during the power-up sweep");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRD) |-> (r_res[0] < MODULUS) && (r_res[1] < MODULUS)
                                && (r_res[2] < MODULUS) && (r_res[3] < MODULUS))
        else $error("bit index not reduced below the filter size");

    a_set_only_if_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRD) |-> !r_all)
        else $error("setting bits of a clause already seen");
`endif

endmodule

// ===== src/clause_bloom_filter_top.sv =====
`timescale 1ns / 1ps
// Top level of the clause duplicate filter (four-hash Bloom filter).
//
// Usage: a clause arrives one item per cycle on i_item, glue word first, last set on
// its final element; command = clear empties the bit store. An item is taken on a
// rising edge with start high and busy low. One result per clause comes out on
// o_result with o_done high for a single cycle; it cannot be held off.
// max_clause_len is written through i_cfg_we / i_cfg_wdata while the block is idle.
//
// Timing: non-final elements go at one per cycle while busy is low (one multiply-xor
// stage per hash). Final elements and clear commands go through a two-entry job queue
// to the bit-store engine; busy rises while that queue is full. Per job the engine
// answers a length-rejected or one-literal clause directly from idle; a hashed clause
// is reduced (multiply, subtract, fix) unless FILTER_BITS is a power of two, then
// tested one hash at a time (read, check) and, if new, set one hash at a time (read,
// write); a clear sweeps one 64-bit row of the bit RAM per cycle.
// Reset: busy stays high while the bit store, FILTER_BITS/64 rows (16384 at the
// default), is swept to zero; configuration writes are taken during that time.
module clause_bloom_filter_top #(
    parameter int FILTER_BITS = 1048576
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cbf_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [cbf_pkg::COUNT_W-1:0]  i_cfg_wdata,
    output logic                         o_done,
    output cbf_pkg::t_result             o_result
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    logic           back_init;
    cbf_pkg::t_job  job_in;
    cbf_pkg::t_job  job_out;

    assign busy   = fifo_full || back_init;
    assign accept = start && !busy;

    cbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_job       (job_in)
    );

    cbf_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    cbf_back #(
        .FILTER_BITS (FILTER_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (fifo_empty),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_init   (back_init),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_full)
        else $error("job pushed into a full queue");
`endif

endmodule
